[hdl/mhpq_pkg.sv]
// Shared types and constants of the max-heap priority queue.
// Used by the channel interfaces, the heap engine, the top level and the checker.
package mhpq_pkg;

	localparam int VALUE_W = 32;
	localparam int TOTAL_W = 7;

	localparam logic FN_INSERT = 1'b0;
	localparam logic FN_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic                      func;
		logic signed [VALUE_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] removed_value;
		logic signed [VALUE_W-1:0] top_value;
		logic [TOTAL_W-1:0]        entry_total;
		status_t                   status;
	} result_t;

endpackage

[hdl/mhpq_ifs.sv]
// Valid/ready channel interfaces for the request and response words of the queue.
// Depends on mhpq_pkg for field widths and the status type.
interface mhpq_req_if import mhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic                      func;
	logic signed [VALUE_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface mhpq_rsp_if import mhpq_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] removed_value;
	logic signed [VALUE_W-1:0] top_value;
	logic [TOTAL_W-1:0]        entry_total;
	status_t                   status;

	modport source (output valid, output removed_value, output top_value,
		output entry_total, output status, input ready);
	modport sink (input valid, input removed_value, input top_value,
		input entry_total, input status, output ready);
endinterface

[hdl/mhpq_engine.sv]
// Heap engine: heap memory, fill count and the sift sequencer around one shared
// signed comparator. Depends on mhpq_pkg for the command and result structs.
module mhpq_engine import mhpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    start,
	input  cmd_t    cmd,
	output logic    idle,
	output logic    res_valid,
	input  logic    res_take,
	output result_t res
);

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam int IW = CW + 1;
	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	typedef enum logic [8:0] {
		S_IDLE    = 9'b000000001,
		S_UP_RD   = 9'b000000010,
		S_UP_CMP  = 9'b000000100,
		S_DN_LAST = 9'b000001000,
		S_DN_RDL  = 9'b000010000,
		S_DN_RDR  = 9'b000100000,
		S_DN_CMP  = 9'b001000000,
		S_WR      = 9'b010000000,
		S_DONE    = 9'b100000000
	} state_t;

	state_t                    state_q, state_d;
	logic [CW-1:0]             count_q;
	logic [AW-1:0]             pos_q;
	logic signed [VALUE_W-1:0] cur_q, best_q, left_q, root_q, rdata_q, removed_q;
	logic                      lgt_q, rvld_q;
	status_t                   status_q;

	logic signed [VALUE_W-1:0] heap_mem [CAPACITY];

	logic [AW-1:0]             parent_idx, last_idx, raddr;
	logic [IW-1:0]             l_idx, r_idx;
	logic                      l_ok, r_ok;
	logic                      re, we, gt;
	logic signed [VALUE_W-1:0] wdata, cmp_a, cmp_b;

	assign parent_idx = AW'((pos_q - 1'b1) >> 1);
	assign last_idx   = AW'(count_q - 1'b1);
	assign l_idx      = IW'({pos_q, 1'b1});
	assign r_idx      = l_idx + 1'b1;
	assign l_ok       = l_idx < IW'(count_q);
	assign r_ok       = r_idx < IW'(count_q);

	always_comb begin
		cmp_a = cur_q;
		cmp_b = rdata_q;
		unique case (state_q)
			S_DN_RDR: begin
				cmp_a = rdata_q;
				cmp_b = cur_q;
			end
			S_DN_CMP: begin
				cmp_a = rdata_q;
				cmp_b = best_q;
			end
			default: begin
				cmp_a = cur_q;
				cmp_b = rdata_q;
			end
		endcase
	end

	assign gt = cmp_a > cmp_b;

	always_comb begin
		state_d = state_q;
		re      = 1'b0;
		raddr   = '0;
		we      = 1'b0;
		wdata   = cur_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					if (cmd.func == FN_INSERT) begin
						if (count_q == CAP_CNT) begin
							state_d = S_DONE;
						end else if (count_q == '0) begin
							state_d = S_WR;
						end else begin
							state_d = S_UP_RD;
						end
					end else begin
						if (count_q == '0 || count_q == CW'(1)) begin
							state_d = S_DONE;
						end else begin
							re      = 1'b1;
							raddr   = last_idx;
							state_d = S_DN_LAST;
						end
					end
				end
			end
			S_UP_RD: begin
				re      = 1'b1;
				raddr   = parent_idx;
				state_d = S_UP_CMP;
			end
			S_UP_CMP: begin
				if (gt) begin
					we      = 1'b1;
					wdata   = rdata_q;
					state_d = (parent_idx == '0) ? S_WR : S_UP_RD;
				end else begin
					state_d = S_WR;
				end
			end
			S_DN_LAST: begin
				state_d = S_DN_RDL;
			end
			S_DN_RDL: begin
				if (l_ok) begin
					re      = 1'b1;
					raddr   = AW'(l_idx);
					state_d = S_DN_RDR;
				end else begin
					state_d = S_WR;
				end
			end
			S_DN_RDR: begin
				if (r_ok) begin
					re    = 1'b1;
					raddr = AW'(r_idx);
				end
				state_d = S_DN_CMP;
			end
			S_DN_CMP: begin
				if (rvld_q && gt) begin
					we      = 1'b1;
					wdata   = rdata_q;
					state_d = S_DN_RDL;
				end else if (lgt_q) begin
					we      = 1'b1;
					wdata   = left_q;
					state_d = S_DN_RDL;
				end else begin
					state_d = S_WR;
				end
			end
			S_WR: begin
				we      = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (res_take) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && start) begin
				if (cmd.func == FN_INSERT && count_q != CAP_CNT) begin
					count_q <= count_q + 1'b1;
				end else if (cmd.func == FN_REMOVE && count_q != '0) begin
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					removed_q <= '0;
					status_q  <= ST_OK;
					cur_q     <= cmd.value;
					if (cmd.func == FN_INSERT) begin
						pos_q <= AW'(count_q);
						if (count_q == CAP_CNT) begin
							status_q <= ST_FULL;
						end
					end else begin
						pos_q <= '0;
						if (count_q == '0) begin
							status_q <= ST_EMPTY;
						end else begin
							removed_q <= root_q;
						end
					end
				end
			end
			S_UP_CMP: begin
				if (gt) begin
					pos_q <= parent_idx;
				end
			end
			S_DN_LAST: begin
				cur_q <= rdata_q;
			end
			S_DN_RDR: begin
				left_q <= rdata_q;
				lgt_q  <= gt;
				best_q <= gt ? rdata_q : cur_q;
				rvld_q <= r_ok;
			end
			S_DN_CMP: begin
				if (rvld_q && gt) begin
					pos_q <= AW'(r_idx);
				end else if (lgt_q) begin
					pos_q <= AW'(l_idx);
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			heap_mem[pos_q] <= wdata;
		end
		if (re) begin
			rdata_q <= heap_mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (we && pos_q == '0) begin
			root_q <= wdata;
		end
	end

	assign idle              = state_q == S_IDLE;
	assign res_valid         = state_q == S_DONE;
	assign res.removed_value = removed_q;
	assign res.top_value     = (count_q != '0) ? root_q : '0;
	assign res.entry_total   = TOTAL_W'(count_q);
	assign res.status        = status_q;

endmodule

[hdl/max_heap_priority_queue_top.sv]
// Top level of the max-heap priority queue: request and response channels,
// response output register and the heap engine. Depends on mhpq_pkg and mhpq_ifs.
//
// Each request word either inserts value (func insert) or removes the maximum
// (func remove); every request gives exactly one response word with the removed
// maximum, the new top, the entry count and a status of ok, full or empty.
// The block takes one request at a time: req.ready is high only while the
// engine is idle. An insert moves its value up level by level until it reaches
// the root or stops under a larger parent; a remove moves the last entry down
// from the root until it ends at a leaf or stops above one. A full insert, an
// empty remove or a remove of the only entry skips the sift. The steps are
// paced by the single heap memory port pair and the one comparator shared by
// all steps. The response word becomes valid in the same cycle in which the
// next request can be taken.
// The response sits in an output register; a new request is accepted while it
// waits, and the engine holds its finished word until the register frees up.
// Reset empties the queue at once; the heap memory needs no clearing.
module max_heap_priority_queue_top import mhpq_pkg::*; #(
	parameter int CAPACITY = 64
) (
	input logic        clk,
	input logic        arst_n,
	mhpq_req_if.sink   req,
	mhpq_rsp_if.source rsp
);

	cmd_t    cmd;
	result_t res;
	logic    eng_idle, res_valid, res_take, start;
	logic    out_valid_q;
	result_t out_q;

	assign cmd.func  = req.func;
	assign cmd.value = req.value;
	assign req.ready = eng_idle;
	assign start     = req.valid && eng_idle;
	assign res_take  = !out_valid_q || rsp.ready;

	mhpq_engine #(
		.CAPACITY(CAPACITY)
	) u_engine (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.cmd      (cmd),
		.idle     (eng_idle),
		.res_valid(res_valid),
		.res_take (res_take),
		.res      (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.removed_value = out_q.removed_value;
	assign rsp.top_value     = out_q.top_value;
	assign rsp.entry_total   = out_q.entry_total;
	assign rsp.status        = out_q.status;

endmodule

[hdl/mhpq_checker.sv]
// Port-level assertions for the max-heap priority queue and the bind that
// attaches them to max_heap_priority_queue_top. Depends on mhpq_pkg.
module mhpq_checker import mhpq_pkg::*; (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rsp_valid,
	input logic                      rsp_ready,
	input logic signed [VALUE_W-1:0] removed_value,
	input logic signed [VALUE_W-1:0] top_value,
	input logic [TOTAL_W-1:0]        entry_total,
	input status_t                   status
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response word dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(removed_value) && $stable(top_value)
			&& $stable(entry_total) && $stable(status))
		else $error("response word changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |->
			removed_value == '0 && top_value == '0 && entry_total == '0)
		else $error("empty remove reported a nonzero field");

	a_full_nothing_removed: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> removed_value == '0 && entry_total != '0)
		else $error("full insert reported a removed value or an empty queue");

endmodule

bind max_heap_priority_queue_top mhpq_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.removed_value(rsp.removed_value),
	.top_value    (rsp.top_value),
	.entry_total  (rsp.entry_total),
	.status       (rsp.status)
);
